### rtl/bsmg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsmg_pkg
// Shared widths, codes and controller/datapath structs for the bounded set
// min/max gap block.
// ----------------------------------------------------------------------------
package bsmg_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;
  localparam int CFG_W   = 7;

  localparam logic [CFG_W-1:0] CAPACITY_RESET = 7'd64;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic RES_OK   = 1'b0;
  localparam logic RES_FULL = 1'b1;

  typedef struct packed {
    logic capture;
    logic eval;
    logic scan_start;
    logic read;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic has_room;
    logic count_zero;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic               status;
    logic [COUNT_W-1:0] count;
    logic               spans_valid;
    logic [DATA_W-1:0]  shortest_span;
    logic [DATA_W-1:0]  longest_span;
  } result_t;

endpackage : bsmg_pkg
`default_nettype wire

### rtl/bsmg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsmg_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bsmg_item_if ();
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [bsmg_pkg::DATA_W-1:0]  value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface : bsmg_item_if

interface bsmg_result_if ();
  logic                              valid;
  logic                              ready;
  logic                              status;
  logic [bsmg_pkg::COUNT_W-1:0]      count;
  logic                              spans_valid;
  logic [bsmg_pkg::DATA_W-1:0]       shortest_span;
  logic [bsmg_pkg::DATA_W-1:0]       longest_span;

  modport source (output valid, output status, output count, output spans_valid,
                  output shortest_span, output longest_span, input ready);
  modport sink   (input valid, input status, input count, input spans_valid,
                  input shortest_span, input longest_span, output ready);
endinterface : bsmg_result_if
`default_nettype wire

### rtl/bsmg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsmg_ctrl
// Sequencer: takes an item, decides add/clear/reject, walks the held values
// through the datapath, commits and hands the result to the output register.
// ----------------------------------------------------------------------------
module bsmg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bsmg_pkg::dp_status_t status_i,
  output bsmg_pkg::dp_cmd_t    cmd_o
);
  import bsmg_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.is_clear || !status_i.has_room) begin
          state_d = ST_FINISH;
        end else if (status_i.count_zero) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.read = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : bsmg_ctrl
`default_nettype wire

### rtl/bsmg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsmg_datapath
// Value store, running min/max/least gap, gap pipeline and result register.
// ----------------------------------------------------------------------------
module bsmg_datapath #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bsmg_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_operation_i,
  input  logic signed [bsmg_pkg::DATA_W-1:0]  in_value_i,
  input  bsmg_pkg::dp_cmd_t                   cmd_i,
  output bsmg_pkg::dp_status_t                status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output bsmg_pkg::result_t                   result_o
);
  import bsmg_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_ENTRIES);

  logic [DATA_W-1:0]        mem_q [MAX_ENTRIES];
  logic [CFG_W-1:0]         capacity_q;
  logic                     op_q;
  logic signed [DATA_W-1:0] value_q;
  logic [CW-1:0]            count_q;
  logic [DATA_W-1:0]        least_gap_q;
  logic signed [DATA_W-1:0] smallest_q;
  logic signed [DATA_W-1:0] largest_q;
  logic [AW-1:0]            idx_q;
  logic                     rvalid_q;
  logic                     gvalid_q;
  logic signed [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0]        gap_q;
  logic [DATA_W-1:0]        gap_d;
  logic                     reject_q;
  logic                     out_valid_q;
  result_t                  res_q;
  logic                     has_room;
  logic                     span_ok;
  logic [LW-1:0]            count_l;
  logic [LW-1:0]            cap_l;

  assign count_l  = LW'(count_q);
  assign cap_l    = LW'(capacity_q);
  assign has_room = (count_l < cap_l) && (count_l < MAX_L);
  assign span_ok  = (count_q >= CW'(2));

  assign status_o.is_clear   = (op_q == OP_CLEAR);
  assign status_o.has_room   = has_room;
  assign status_o.count_zero = (count_q == '0);
  assign status_o.scan_last  = (CW'(idx_q) == (count_q - CW'(1)));
  assign status_o.pipe_busy  = rvalid_q || gvalid_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    if (value_q >= rdata_q) begin
      gap_d = $unsigned(value_q - rdata_q);
    end else begin
      gap_d = $unsigned(rdata_q - value_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_operation_i;
      value_q <= in_value_i;
    end
    if (rvalid_q) begin
      gap_q <= gap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_q[count_q[AW-1:0]] <= value_q;
    end
    if (cmd_i.read) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      least_gap_q <= '1;
      smallest_q  <= '0;
      largest_q   <= '0;
      idx_q       <= '0;
      rvalid_q    <= 1'b0;
      gvalid_q    <= 1'b0;
      reject_q    <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.read;
      gvalid_q <= rvalid_q;
      if (cmd_i.scan_start) begin
        idx_q <= '0;
      end else if (cmd_i.read) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.eval) begin
        reject_q <= (op_q == OP_ADD) && !has_room;
        if (op_q == OP_CLEAR) begin
          count_q     <= '0;
          least_gap_q <= '1;
          smallest_q  <= '0;
          largest_q   <= '0;
        end
      end
      if (gvalid_q && (gap_q < least_gap_q)) begin
        least_gap_q <= gap_q;
      end
      if (cmd_i.commit) begin
        count_q <= count_q + CW'(1);
        if (count_q == '0) begin
          smallest_q <= value_q;
          largest_q  <= value_q;
        end else begin
          if (value_q < smallest_q) begin
            smallest_q <= value_q;
          end
          if (value_q > largest_q) begin
            largest_q <= value_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_q.status        <= reject_q ? RES_FULL : RES_OK;
      res_q.count         <= COUNT_W'(count_q);
      res_q.spans_valid   <= span_ok;
      res_q.shortest_span <= span_ok ? least_gap_q : '0;
      res_q.longest_span  <= span_ok ? $unsigned(largest_q - smallest_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule : bsmg_datapath
`default_nettype wire

### rtl/bounded_set_min_max_gap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_set_min_max_gap
// Bounded set of signed 32-bit values reporting count, least gap and span.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries items (operation, value); an item transfers when valid and
//   ready are high at a rising edge. out_o returns one result per item.
//   cfg_we_i/cfg_wdata_i write the capacity; write only while the block idles.
// Sequence:
//   A clear or a rejected add passes from transfer through the evaluate and
//   finish states to result valid. An accepted add into an empty set commits
//   straight after evaluation; otherwise the held values are read from the
//   store one per cycle, and each difference passes a two-stage gap pipeline
//   before it is folded into the least gap. One item is in flight at a time;
//   in_i.ready is high whenever the sequencer is idle, also while a result
//   waits on out_o; the next item may transfer as soon as the result is valid.
// Reset:
//   Set empty, least gap all ones, min/max zero, capacity 64, no result
//   pending. The store itself is not cleared.
// Stall:
//   A result holds on out_o until taken; the next item may transfer
//   meanwhile and its result waits in the sequencer until out_o frees.
// ----------------------------------------------------------------------------
module bounded_set_min_max_gap #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bsmg_pkg::CFG_W-1:0]  cfg_wdata_i,
  bsmg_item_if.sink                   in_i,
  bsmg_result_if.source               out_o
);
  import bsmg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    result;
  logic       out_valid;
  logic       in_ready;

  bsmg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsmg_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_operation_i (in_i.operation),
    .in_value_i     (in_i.value),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_valid),
    .result_o       (result)
  );

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid;
  assign out_o.status        = result.status;
  assign out_o.count         = result.count;
  assign out_o.spans_valid   = result.spans_valid;
  assign out_o.shortest_span = result.shortest_span;
  assign out_o.longest_span  = result.longest_span;

endmodule : bounded_set_min_max_gap
`default_nettype wire

### rtl/bsmg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsmg_checker
// Port-level properties of the bounded set min/max gap block.
// ----------------------------------------------------------------------------
module bsmg_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [bsmg_pkg::COUNT_W-1:0]  count_i,
  input  logic                          spans_valid_i,
  input  logic [bsmg_pkg::DATA_W-1:0]   shortest_span_i,
  input  logic [bsmg_pkg::DATA_W-1:0]   longest_span_i
);
  import bsmg_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped before transfer");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("second item taken while one is in flight");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && spans_valid_i) |-> (shortest_span_i <= longest_span_i))
    else $error("least gap exceeds span");

  a_span_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !spans_valid_i) |->
      ((count_i < COUNT_W'(2)) && (shortest_span_i == '0) && (longest_span_i == '0)))
    else $error("spans reported without two held values");

endmodule : bsmg_checker

bind bounded_set_min_max_gap bsmg_checker u_bsmg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .count_i         (out_o.count),
  .spans_valid_i   (out_o.spans_valid),
  .shortest_span_i (out_o.shortest_span),
  .longest_span_i  (out_o.longest_span)
);
`default_nettype wire

### sim/bounded_set_min_max_gap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_set_min_max_gap_test
// Self-checking bench for the bounded set with shortest and longest span.
// Directed items cover the value extremes, duplicates, clears and the capacity
// corner cases. Random phases follow, each with its own capacity. A
// scoreboard predicts each result from its own copy of the set and checks
// every result transfer field by field. Both sides idle at random. The sink
// holds off once for a long stretch, and the source drains once mid-phase.
// ----------------------------------------------------------------------------
module bounded_set_min_max_gap_test;
  import bsmg_pkg::*;

  localparam int STORE_DEPTH     = 64;
  localparam int PHASES          = 11;
  localparam int PHASE_ITEMS     = 155;
  localparam int HOLD_OFF_CYCLES = 320;
  localparam int TAIL_CYCLES     = STORE_DEPTH + 16;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int REPORT_LIMIT    = 10;

  class span_scoreboard;
    logic signed [DATA_W-1:0] held [STORE_DEPTH];
    int unsigned              held_n;
    logic [DATA_W-1:0]        least_gap;
    logic signed [DATA_W-1:0] low_val;
    logic signed [DATA_W-1:0] high_val;
    int unsigned              cap;
    result_t                  expected_spans [$];
    int unsigned              errors;

    function new();
      foreach (held[i]) held[i] = '0;
      cap    = CAPACITY_RESET;
      errors = 0;
      empty_set();
    endfunction

    function void empty_set();
      held_n    = 0;
      least_gap = '1;
      low_val   = '0;
      high_val  = '0;
    endfunction

    function void set_capacity(int unsigned c);
      cap = c;
    endfunction

    function int unsigned pending();
      return expected_spans.size();
    endfunction

    function void note_item(logic op, logic signed [DATA_W-1:0] v);
      result_t           r;
      int unsigned       room;
      int unsigned       i;
      logic [DATA_W-1:0] gap;
      room = (cap < STORE_DEPTH) ? cap : STORE_DEPTH;
      r = '0;
      r.status = RES_OK;
      if (op == OP_CLEAR) begin
        empty_set();
      end else if (held_n < room) begin
        for (i = 0; i < held_n; i++) begin
          gap = (v >= held[i]) ? v - held[i] : held[i] - v;
          if (gap < least_gap) least_gap = gap;
        end
        if (held_n == 0) begin
          low_val  = v;
          high_val = v;
        end else begin
          if (v < low_val) low_val = v;
          if (v > high_val) high_val = v;
        end
        held[held_n] = v;
        held_n++;
      end else begin
        r.status = RES_FULL;
      end
      r.count       = COUNT_W'(held_n);
      r.spans_valid = (held_n >= 2);
      if (r.spans_valid) begin
        r.shortest_span = least_gap;
        r.longest_span  = high_val - low_val;
      end
      expected_spans = {expected_spans, r};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_spans.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result with nothing pending: status=%0d count=%0d valid=%0d short=%h long=%h",
                   got.status, got.count, got.spans_valid, got.shortest_span,
                   got.longest_span);
        return;
      end
      want = expected_spans.pop_front();
      if (got.status !== want.status || got.count !== want.count ||
          got.spans_valid !== want.spans_valid ||
          got.shortest_span !== want.shortest_span ||
          got.longest_span !== want.longest_span) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("mismatch: want status=%0d count=%0d valid=%0d short=%h long=%h",
                   want.status, want.count, want.spans_valid, want.shortest_span,
                   want.longest_span);
          $display("          got  status=%0d count=%0d valid=%0d short=%h long=%h",
                   got.status, got.count, got.spans_valid, got.shortest_span,
                   got.longest_span);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                steady;
  logic                hold_off_req;
  int unsigned         stall_cycles;
  result_t             got;
  span_scoreboard      tracker = new();

  bsmg_item_if   items ();
  bsmg_result_if results ();

  bounded_set_min_max_gap #(
    .MAX_ENTRIES(STORE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (items),
    .out_o      (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sink side: random ready, one long hold-off on request
  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req  <= 1'b0;
        results.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      results.ready <= steady || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk_i) begin
    if (results.valid && results.ready) begin
      got.status        = results.status;
      got.count         = results.count;
      got.spans_valid   = results.spans_valid;
      got.shortest_span = results.shortest_span;
      got.longest_span  = results.longest_span;
      tracker.check_result(got);
    end
    if ((items.valid && items.ready) || (results.valid && results.ready) || !rst_ni)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(logic op, logic signed [DATA_W-1:0] v);
    while (!steady && $urandom_range(99) < 22) begin
      items.valid <= 1'b0;
      @(negedge clk_i);
    end
    items.valid     <= 1'b1;
    items.operation <= op;
    items.value     <= v;
    @(posedge clk_i);
    while (!items.ready) @(posedge clk_i);
    tracker.note_item(op, v);
    @(negedge clk_i);
  endtask

  task automatic drain();
    items.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_capacity(int unsigned c);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(c);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_capacity(c);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(logic signed [DATA_W-1:0] base);
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3, 4, 5: v = base + $urandom_range(64) - 32;
      6: begin
        case ($urandom_range(5))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = '0;
          3:       v = '1;
          4:       v = 32'h8000_0001;
          default: v = 32'h7FFF_FFFE;
        endcase
      end
      7: v = (tracker.held_n != 0) ? tracker.held[$urandom_range(tracker.held_n - 1)] : base;
      default: v = base + ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
    endcase
    return v;
  endfunction

  initial begin
    int                       phase_cap [PHASES] = '{64, 127, 3, 0, 1, 2, 17, 63, 65, -1, -1};
    int unsigned              clear_pct [PHASES] = '{2, 1, 6, 10, 10, 8, 4, 2, 2, 3, 3};
    int unsigned              ph;
    int unsigned              n;
    logic signed [DATA_W-1:0] base;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    items.valid     = 1'b0;
    items.operation = OP_ADD;
    items.value     = '0;
    steady          = 1'b0;
    hold_off_req    = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes, duplicates, single value, clear
    send_item(OP_CLEAR, '0);
    send_item(OP_ADD, 32'h8000_0000);
    send_item(OP_ADD, 32'h7FFF_FFFF);
    send_item(OP_ADD, '0);
    send_item(OP_ADD, '0);
    send_item(OP_ADD, '1);
    send_item(OP_CLEAR, 32'h1234_5678);
    send_item(OP_ADD, 5);
    send_item(OP_ADD, 5);
    send_item(OP_ADD, 7);
    // zero capacity, lowered below count
    write_capacity(0);
    send_item(OP_ADD, 1);
    send_item(OP_CLEAR, '0);
    send_item(OP_ADD, 2);
    // capacity above storage
    write_capacity(127);
    send_item(OP_ADD, 32'h8000_0000);
    send_item(OP_ADD, 32'h7FFF_FFFE);
    send_item(OP_ADD, 100);
    // two slots, lowered below count first
    write_capacity(2);
    send_item(OP_ADD, 3);
    send_item(OP_CLEAR, '0);
    send_item(OP_ADD, 1);
    send_item(OP_ADD, '1);
    send_item(OP_ADD, 9);

    for (ph = 0; ph < PHASES; ph++) begin
      write_capacity((phase_cap[ph] < 0) ? $urandom_range(127) : phase_cap[ph]);
      if (ph == 7) steady <= 1'b1;
      if (ph == 8) steady <= 1'b0;
      base = $urandom;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 60) hold_off_req <= 1'b1;
        if (ph == 6 && n == 80) drain();
        if (n % 40 == 39) base = $urandom;
        if ($urandom_range(99) < clear_pct[ph])
          send_item(OP_CLEAR, $urandom);
        else
          send_item(OP_ADD, pick_value(base));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule : bounded_set_min_max_gap_test
